FILE: rtl/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM target.
// No dependencies; imported by i2cee_reply and i2c_eeprom_target_unit.
package i2cee_pkg;

  // Width of the address pointer registers (base and offset)
  localparam int unsigned PTR_W = 16;

  // Control code bits; a start is refused unless it carries at least one of them
  localparam logic [7:0] CONTROL_CODE = 8'hA0;

  // Data field carried by an acknowledge
  localparam logic [7:0] ACK_BYTE = 8'h01;

  typedef enum logic [1:0] {
    PH_STOPPED   = 2'd0,
    PH_ADDR_HIGH = 2'd1,
    PH_ADDR_LOW  = 2'd2,
    PH_STARTED   = 2'd3
  } phase_t;

  typedef enum logic {
    REPLY_ACK  = 1'b0,
    REPLY_DATA = 1'b1
  } reply_kind_t;

  // Replies owed for one bus event: acknowledges first, then an optional read byte
  typedef struct packed {
    logic [1:0] acks;
    logic       rd;
    logic [2:0] sel;
  } reply_set_t;

endpackage

FILE: rtl/i2c_eeprom_target_unit.sv
// Top level of the byte-level I2C EEPROM target.
// Depends on i2cee_pkg and i2cee_reply.

// One bus event is accepted per clock cycle while in_ready is high. The
// event's address pointer and phase are worked out in the accepting cycle, a
// stored byte is written and a read byte is fetched from the
// single-port-per-direction storage memory in the same cycle, and the read
// data is registered. Replies leave through an output buffer one per cycle
// while out_ready is high, none to three per event; the first reply is
// offered once the reply set has passed the stage register into the output
// buffer. After reset the memory is cleared one byte a cycle; no event is
// accepted during that pass, while device_select writes are taken as ever.
module i2c_eeprom_target_unit import i2cee_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [2:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cond_stop,
  input  logic       cond_start,
  input  logic       cond_write,
  input  logic       cond_read,
  input  logic [7:0] bus_address,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       reply_kind,
  output logic [2:0] reply_select,
  output logic [7:0] reply_data,
  output logic       last
);

  localparam int unsigned MEM_DEPTH = 1 << ADDRESS_BITS;

  // Configuration and session state
  logic [2:0]       device_select;
  phase_t           phase;
  phase_t           phase_next;
  logic [PTR_W-1:0] base_address;
  logic [PTR_W-1:0] base_address_next;
  logic [PTR_W-1:0] offset_count;
  logic [PTR_W-1:0] offset_count_next;

  // Event decode
  logic             accept;
  logic             matched;
  logic             refused;
  logic             store;
  logic             fetch;
  logic [1:0]       acks;
  logic [PTR_W-1:0] wr_sum;
  logic [PTR_W-1:0] rd_sum;

  // Storage memory
  logic [7:0]              mem [MEM_DEPTH];
  logic                    mem_we;
  logic [ADDRESS_BITS-1:0] mem_waddr;
  logic [7:0]              mem_wdata;
  logic                    mem_re;
  logic [ADDRESS_BITS-1:0] mem_raddr;
  logic [7:0]              rd_q;

  // Clearing pass
  logic                    clr_busy;
  logic [ADDRESS_BITS-1:0] clr_addr;

  // Stage between acceptance and the output buffer
  logic       s1_valid;
  reply_set_t s1_set;
  logic       s1_ready;
  logic       s1_move;

  assign accept   = in_valid && in_ready;
  assign s1_ready = !s1_valid || s1_move;
  assign in_ready = !clr_busy && s1_ready;

  // Apply stop, start, write, read in order; an unmatched start just stops
  always_comb begin
    phase_next        = phase;
    base_address_next = base_address;
    offset_count_next = offset_count;
    refused           = 1'b0;
    store             = 1'b0;
    fetch             = 1'b0;
    acks              = 2'd0;
    wr_sum            = '0;
    rd_sum            = '0;
    matched           = (bus_address[3:1] == device_select);
    if (!matched) begin
      if (cond_start) begin
        phase_next        = PH_STOPPED;
        base_address_next = '0;
        offset_count_next = '0;
      end
    end else begin
      if (cond_stop) begin
        phase_next        = PH_STOPPED;
        base_address_next = '0;
        offset_count_next = '0;
      end
      if (cond_start) begin
        if ((bus_address & CONTROL_CODE) == 8'h00) begin
          refused = 1'b1;
        end else begin
          phase_next = bus_address[0] ? PH_STARTED : PH_ADDR_HIGH;
          acks       = acks + 2'd1;
        end
      end
      if (cond_write && !refused) begin
        case (phase_next)
          PH_ADDR_HIGH: begin
            base_address_next = {data_byte, 8'h00};
            offset_count_next = '0;
            phase_next        = PH_ADDR_LOW;
          end
          PH_ADDR_LOW: begin
            base_address_next = {base_address_next[PTR_W-1:8], data_byte};
            phase_next        = PH_STARTED;
          end
          PH_STARTED: begin
            store = 1'b1;
          end
          default: begin
          end
        endcase
        acks = acks + 2'd1;
      end
      // Write location, then advance the offset for a stored byte
      wr_sum = base_address_next + offset_count_next;
      if (store) begin
        offset_count_next = offset_count_next + 16'd1;
      end
      // Read location follows any store of the same event
      rd_sum = base_address_next + offset_count_next;
      if (cond_read && !refused) begin
        fetch             = 1'b1;
        offset_count_next = offset_count_next + 16'd1;
      end
    end
  end

  // Hold the select register; write it from the configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      device_select <= 3'd0;
    end else if (cfg_write_en) begin
      device_select <= cfg_write_data;
    end
  end

  // Advance the session state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STOPPED;
      base_address <= '0;
      offset_count <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      base_address <= base_address_next;
      offset_count <= offset_count_next;
    end
  end

  // Sweep the memory to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {ADDRESS_BITS{1'b1}}) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Memory ports; a store and a fetch of one item never share a location
  assign mem_we    = clr_busy || (accept && store);
  assign mem_waddr = clr_busy ? clr_addr : wr_sum[ADDRESS_BITS-1:0];
  assign mem_wdata = clr_busy ? 8'h00 : data_byte;
  assign mem_re    = accept && fetch;
  assign mem_raddr = rd_sum[ADDRESS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Read data register holds until the next fetch
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // Carry the reply set alongside the memory read; drop items with no reply
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= accept && ((acks != 2'd0) || fetch);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_set.acks <= acks;
      s1_set.rd   <= fetch;
      s1_set.sel  <= device_select;
    end
  end

  logic ob_load_ready;

  assign s1_move = s1_valid && ob_load_ready;

  i2cee_reply u_reply (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (s1_valid),
    .load_set     (s1_set),
    .load_data    (rd_q),
    .load_ready   (ob_load_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reply_kind   (reply_kind),
    .reply_select (reply_select),
    .reply_data   (reply_data),
    .last         (last)
  );

  // A fetch and a store issued together never address the same byte
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("store and fetch hit the same location");

  // The clearing pass ends only after the top location is written
  assert property (@(posedge clk) disable iff (rst)
    $fell(clr_busy) |-> ($past(clr_addr) == {ADDRESS_BITS{1'b1}}))
    else $error("clearing pass ended early");

  // A waiting reply set is never lost
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> s1_valid)
    else $error("pending reply set dropped");

  // More replies follow a non-final one
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> out_valid)
    else $error("reply set cut short");

endmodule

FILE: rtl/i2cee_reply.sv
// Output buffer of the I2C EEPROM target: holds one event's reply set and
// hands its replies out one per handshake. Depends on i2cee_pkg.
module i2cee_reply import i2cee_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  input  reply_set_t       load_set,
  input  logic [7:0]       load_data,
  output logic             load_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             reply_kind,
  output logic [2:0]       reply_select,
  output logic [7:0]       reply_data,
  output logic             last
);

  logic       ob_valid;
  logic [1:0] ob_acks;
  logic       ob_rd;
  logic [2:0] ob_sel;
  logic [7:0] ob_data;
  logic       fire;
  logic       finish;

  // Acknowledges go out first; the read byte, if any, closes the set
  assign out_valid    = ob_valid;
  assign reply_kind   = (ob_acks == 2'd0) ? REPLY_DATA : REPLY_ACK;
  assign reply_select = ob_sel;
  assign reply_data   = (ob_acks == 2'd0) ? ob_data : ACK_BYTE;
  assign last         = (ob_acks == 2'd0) || (ob_acks == 2'd1 && !ob_rd);

  assign fire       = ob_valid && out_ready;
  assign finish     = fire && last;
  assign load_ready = !ob_valid || finish;

  // Hold the current set; load the next one as the last reply leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      ob_acks  <= 2'd0;
    end else if (load_ready) begin
      ob_valid <= load_valid;
      ob_acks  <= load_set.acks;
    end else if (fire && ob_acks != 2'd0) begin
      ob_acks <= ob_acks - 2'd1;
    end
  end

  // Payload of the set needs no reset
  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      ob_rd   <= load_set.rd;
      ob_sel  <= load_set.sel;
      ob_data <= load_data;
    end
  end

endmodule
